FILE: hw/rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg : shared types and constants of the spectral feature extractor
// Word layouts, widths derived from the spectrum size and the exp2 table.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int HARM_COUNT = 10;
  localparam int HARM_SPAN  = 2;

  localparam int MAG_W  = 24;
  localparam int BIN_AW = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int TOT_W  = MAG_W + BIN_AW;
  localparam int WS_W   = MAG_W + 2 * BIN_AW;
  localparam int LS_W   = 48;
  localparam int HSUM_W = MAG_W + $clog2(HARM_COUNT * (2 * HARM_SPAN + 1) + 1);
  localparam int RES_W  = 17;
  localparam int PEAK_W = 10;

  localparam int SR_W   = 18;
  localparam int EDGE_W = 17;
  localparam int MINF_W = 10;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 18;

  localparam logic [CFG_IW-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IW-1:0] REG_EDGE_LOW    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_EDGE_LM     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_EDGE_MH     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_EDGE_HIGH   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIN_FUND    = 3'd5;

  // shared multiply-divide unit
  localparam int MD_AW = (WS_W > LS_W) ? WS_W : LS_W;
  localparam int MD_BW = 18;
  localparam int MD_PW = MD_AW + MD_BW;
  localparam int MD_CW = TOT_W + CNT_W + 1;

  localparam int RATIO_ONE = 65536;
  localparam int Q_DEPTH   = 4;
  localparam int QA_W      = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } in_word_t;

  typedef struct packed {
    logic [RES_W-1:0]  centroid_hz;
    logic [RES_W-1:0]  low_ratio;
    logic [RES_W-1:0]  mid_ratio;
    logic [RES_W-1:0]  high_ratio;
    logic [RES_W-1:0]  flatness;
    logic [RES_W-1:0]  harmonic_ratio;
    logic [PEAK_W-1:0] peak_index;
  } out_word_t;

  typedef struct packed {
    logic [SR_W-1:0]   sr;
    logic [EDGE_W-1:0] e_low;
    logic [EDGE_W-1:0] e_lm;
    logic [EDGE_W-1:0] e_mh;
    logic [EDGE_W-1:0] e_high;
    logic [MINF_W-1:0] minf;
  } cfg_t;

  // classified bin word passed from front end to back end
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic              last;
    logic              store;
    logic [BIN_AW-1:0] idx;
    logic [CNT_W-1:0]  n;
  } q_word_t;

  typedef struct packed {
    logic             start;
    logic [MD_AW-1:0] a;
    logic [MD_BW-1:0] b;
    logic [MD_CW-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [MD_PW-1:0] q;
  } md_rsp_t;

  // 2^(2^-(k+1)) in Q30
  function automatic logic [31:0] exp2_tab(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'd1518500250;
      4'd1:    v = 32'd1276901417;
      4'd2:    v = 32'd1170923762;
      4'd3:    v = 32'd1121280435;
      4'd4:    v = 32'd1097253708;
      4'd5:    v = 32'd1085434106;
      4'd6:    v = 32'd1079572136;
      4'd7:    v = 32'd1076653028;
      4'd8:    v = 32'd1075196444;
      4'd9:    v = 32'd1074468888;
      4'd10:   v = 32'd1074105294;
      4'd11:   v = 32'd1073923544;
      4'd12:   v = 32'd1073832680;
      4'd13:   v = 32'd1073787251;
      4'd14:   v = 32'd1073764537;
      default: v = 32'd1073753181;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/sfe_ram.sv
// ----------------------------------------------------------------------------
// sfe_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/sfe_muldiv.sv
// ----------------------------------------------------------------------------
// sfe_muldiv : serial floor(a*b/c)
// Shift-add multiply one bit of b per cycle, then restoring divide one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfe_muldiv import sfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam int STEP_W = $clog2(MD_PW);

  logic [1:0]        ph_r;
  logic [STEP_W-1:0] step_r;
  logic [MD_AW-1:0]  a_r;
  logic [MD_BW-1:0]  b_r;
  logic [MD_CW-1:0]  c_r;
  logic [MD_PW-1:0]  p_r;
  logic [MD_CW-1:0]  r_r;
  logic              done_r;

  logic [MD_CW:0] rem_s;
  logic [MD_CW:0] rem_sub;
  logic           ge;

  assign rem_s   = {r_r, p_r[MD_PW-1]};
  assign rem_sub = rem_s - {1'b0, c_r};
  assign ge      = (rem_s >= {1'b0, c_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            a_r    <= req.a;
            b_r    <= req.b;
            c_r    <= req.c;
            p_r    <= '0;
            r_r    <= '0;
            step_r <= '0;
            ph_r   <= PH_MUL;
          end
        end
        PH_MUL: begin
          p_r    <= {p_r[MD_PW-2:0], 1'b0} + (b_r[MD_BW-1] ? MD_PW'(a_r) : '0);
          b_r    <= {b_r[MD_BW-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MD_BW - 1)) begin
            step_r <= '0;
            ph_r   <= PH_DIV;
          end
        end
        PH_DIV: begin
          p_r    <= {p_r[MD_PW-2:0], ge};
          r_r    <= ge ? rem_sub[MD_CW-1:0] : rem_s[MD_CW-1:0];
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(MD_PW - 1)) begin
            ph_r   <= PH_IDLE;
            done_r <= 1'b1;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = p_r;

endmodule

FILE: hw/rtl/sfe_front.sv
// ----------------------------------------------------------------------------
// sfe_front : bin intake and classification
// Numbers each bin, marks whether it is stored and counts the spectrum.
// ----------------------------------------------------------------------------
module sfe_front import sfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     q_push,
  output q_word_t  q_word
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             store;

  assign store    = (cnt_r < CNT_W'(MAX_BINS));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_word.mag   = in_data.magnitude;
    q_word.last  = in_data.last_bin;
    q_word.store = store;
    q_word.idx   = cnt_r[BIN_AW-1:0];
    q_word.n     = store ? cnt_r + 1'b1 : cnt_r;
    cnt_nxt      = in_data.last_bin ? '0 : q_word.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/sfe_back.sv
// ----------------------------------------------------------------------------
// sfe_back : bin accumulation and closing computation
// Stores bins, keeps running sums and log2 per bin, then walks the store
// and drives the shared multiply-divide unit to build the result word.
// ----------------------------------------------------------------------------
module sfe_back import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_word_t   q_head,
  input  logic      q_valid,
  output logic      q_pop,
  output logic      out_valid,
  output out_word_t out_data,
  input  logic      out_stall
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOG  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_MD   = 3'd3;
  localparam logic [2:0] S_BAND = 3'd4;
  localparam logic [2:0] S_HARM = 3'd5;
  localparam logic [2:0] S_EXP  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [3:0] OP_DEN = 4'd0;
  localparam logic [3:0] OP_CEN = 4'd1;
  localparam logic [3:0] OP_E0  = 4'd2;
  localparam logic [3:0] OP_E1  = 4'd3;
  localparam logic [3:0] OP_E2  = 4'd4;
  localparam logic [3:0] OP_E3  = 4'd5;
  localparam logic [3:0] OP_BL  = 4'd6;
  localparam logic [3:0] OP_BM  = 4'd7;
  localparam logic [3:0] OP_BH  = 4'd8;
  localparam logic [3:0] OP_HR  = 4'd9;
  localparam logic [3:0] OP_LQ  = 4'd10;
  localparam logic [3:0] OP_FL  = 4'd11;

  localparam int HH_W = $clog2(HARM_COUNT + 2);
  localparam int HD_W = $clog2(2 * HARM_SPAN + 2);
  localparam int HC_W = CNT_W + 1;
  localparam int HB_W = CNT_W + 2;

  logic [2:0]        state_r;
  logic [TOT_W-1:0]  total_r;
  logic [WS_W-1:0]   wsum_r;
  logic [LS_W-1:0]   lsum_r;
  logic [CNT_W-1:0]  nz_r;
  logic [MAG_W-1:0]  pkval_r;
  logic [BIN_AW-1:0] pkidx_r;
  logic [CNT_W-1:0]  n_r;
  logic              last_r;

  logic [31:0]       y_r;
  logic [15:0]       frac_r;
  logic [4:0]        le_r;
  logic [3:0]        k_r;

  logic [3:0]        op_r;
  logic              md_start_r;
  logic [MD_CW-1:0]  den_r;
  logic [CNT_W-1:0]  edge_r [4];
  logic [31:0]       lq_r;
  logic [MD_AW-1:0]  g_r;

  logic [CNT_W-1:0]  rd_idx_r;
  logic              rv_r;
  logic [CNT_W-1:0]  rj_r;
  logic [TOT_W-1:0]  bsum_r [3];

  logic [HC_W-1:0]   hc_r;
  logic [HH_W-1:0]   hh_r;
  logic [HD_W-1:0]   hd_r;
  logic [HSUM_W-1:0] hsum_r;
  logic              harm_en_r;

  logic [31:0]       acc_r;
  logic [3:0]        ek_r;

  logic [RES_W-1:0]  cen_r, rl_r, rm_r, rh_r, fl_r, hr_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  // per-bin datapath
  logic [MAG_W-1:0]  m;
  logic              counted;
  logic [4:0]        le_c;
  logic [31:0]       y_init;
  logic [63:0]       sq;
  logic [33:0]       y2;
  logic [31:0]       y_nxt;
  logic [15:0]       frac_nxt;

  // exp2 datapath
  logic [63:0]       eprod;
  logic [31:0]       acc_nxt;
  logic [MD_PW-1:0]  g_full;

  // walks
  logic              rd_en;
  logic [BIN_AW-1:0] raddr;
  logic [MAG_W-1:0]  rdata;
  logic              h_active;
  logic [HB_W-1:0]   hb;
  logic              h_in;

  logic [31:0]       fund_lhs;
  logic [31:0]       fund_rhs;

  md_req_t           md_req;
  md_rsp_t           md_rsp;

  function automatic logic [RES_W-1:0] sat_ratio(input logic [MD_PW-1:0] q);
    return (q > MD_PW'(RATIO_ONE)) ? RES_W'(RATIO_ONE) : q[RES_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_bin(input logic [MD_PW-1:0] q);
    return (q > MD_PW'(MAX_BINS)) ? CNT_W'(MAX_BINS) : q[CNT_W-1:0];
  endfunction

  assign m       = q_head.mag;
  assign counted = q_head.store && (q_head.idx != '0);
  assign q_pop   = (state_r == S_IDLE) && q_valid;

  always_comb begin
    le_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) le_c = 5'(i);
    end
  end

  assign y_init   = 32'(m) << (5'd30 - le_c);
  assign sq       = 64'(y_r) * 64'(y_r);
  assign y2       = sq[63:30];
  assign y_nxt    = y2[31] ? y2[32:1] : y2[31:0];
  assign frac_nxt = {frac_r[14:0], y2[31]};

  assign eprod   = 64'(acc_r) * 64'(exp2_tab(ek_r));
  assign acc_nxt = lq_r[4'd15 - ek_r] ? eprod[61:30] : acc_r;
  assign g_full  = (MD_PW'(acc_nxt) << lq_r[20:16]) >> 14;

  assign fund_lhs = 32'(pkidx_r) * 32'(cfg.sr);
  assign fund_rhs = 32'(cfg.minf) * 32'({n_r, 1'b0});

  // harmonic window position; bin = hb - span, kept in 1..n-1
  assign h_active = (hh_r <= HH_W'(HARM_COUNT)) && (hc_r <= HC_W'(n_r));
  assign hb       = HB_W'(hc_r) + HB_W'(hd_r);
  assign h_in     = (hb > HB_W'(HARM_SPAN)) && (hb < HB_W'(n_r) + HB_W'(HARM_SPAN));

  always_comb begin
    rd_en = 1'b0;
    raddr = rd_idx_r[BIN_AW-1:0];
    if (state_r == S_BAND) begin
      rd_en = (rd_idx_r < n_r);
    end else if (state_r == S_HARM) begin
      rd_en = h_active && h_in;
      raddr = BIN_AW'(hb - HB_W'(HARM_SPAN));
    end
  end

  always_comb begin
    md_req.start = md_start_r;
    md_req.a     = '0;
    md_req.b     = '0;
    md_req.c     = '0;
    case (op_r)
      OP_DEN: begin
        md_req.a = MD_AW'(total_r);
        md_req.b = MD_BW'({n_r, 1'b0});
        md_req.c = MD_CW'(1);
      end
      OP_CEN: begin
        md_req.a = MD_AW'(wsum_r);
        md_req.b = MD_BW'(cfg.sr);
        md_req.c = den_r;
      end
      OP_E0, OP_E1, OP_E2, OP_E3: begin
        case (op_r)
          OP_E0:   md_req.a = MD_AW'(cfg.e_low);
          OP_E1:   md_req.a = MD_AW'(cfg.e_lm);
          OP_E2:   md_req.a = MD_AW'(cfg.e_mh);
          default: md_req.a = MD_AW'(cfg.e_high);
        endcase
        md_req.b = MD_BW'({n_r, 1'b0});
        md_req.c = MD_CW'(cfg.sr);
      end
      OP_BL, OP_BM, OP_BH: begin
        case (op_r)
          OP_BL:   md_req.a = MD_AW'(bsum_r[0]);
          OP_BM:   md_req.a = MD_AW'(bsum_r[1]);
          default: md_req.a = MD_AW'(bsum_r[2]);
        endcase
        md_req.b = MD_BW'(RATIO_ONE);
        md_req.c = MD_CW'(total_r);
      end
      OP_HR: begin
        md_req.a = MD_AW'(hsum_r);
        md_req.b = MD_BW'(RATIO_ONE);
        md_req.c = MD_CW'(total_r);
      end
      OP_LQ: begin
        md_req.a = MD_AW'(lsum_r);
        md_req.b = MD_BW'(1);
        md_req.c = MD_CW'(nz_r);
      end
      OP_FL: begin
        md_req.a = g_r;
        md_req.b = MD_BW'(nz_r);
        md_req.c = MD_CW'(total_r);
      end
      default: md_req.start = 1'b0;
    endcase
  end

  sfe_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  sfe_ram #(.WIDTH(MAG_W), .DEPTH(MAX_BINS)) u_store (
    .clk   (clk),
    .we    (q_pop && q_head.store),
    .waddr (q_head.idx),
    .wdata (q_head.mag),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      wsum_r      <= '0;
      lsum_r      <= '0;
      nz_r        <= '0;
      pkval_r     <= '0;
      pkidx_r     <= BIN_AW'(1);
      md_start_r  <= 1'b0;
      op_r        <= OP_DEN;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      md_start_r <= 1'b0;
      rv_r       <= rd_en;
      rj_r       <= rd_idx_r;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (rv_r && state_r == S_BAND) begin
        for (int k = 0; k < 3; k++) begin
          if (rj_r >= edge_r[k] && rj_r <= edge_r[k+1]) begin
            bsum_r[k] <= bsum_r[k] + TOT_W'(rdata);
          end
        end
      end
      if (rv_r && state_r == S_HARM) begin
        hsum_r <= hsum_r + HSUM_W'(rdata);
      end

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            n_r    <= q_head.n;
            last_r <= q_head.last;
            if (counted) begin
              total_r <= total_r + TOT_W'(m);
              wsum_r  <= wsum_r + WS_W'(WS_W'(q_head.idx) * WS_W'(m));
              if (m > pkval_r) begin
                pkval_r <= m;
                pkidx_r <= q_head.idx;
              end
            end
            if (counted && m != '0) begin
              y_r     <= y_init;
              le_r    <= le_c;
              frac_r  <= '0;
              k_r     <= '0;
              state_r <= S_LOG;
            end else if (q_head.last) begin
              state_r <= S_FIN;
            end
          end
        end

        S_LOG: begin
          y_r    <= y_nxt;
          frac_r <= frac_nxt;
          k_r    <= k_r + 1'b1;
          if (k_r == 4'd15) begin
            lsum_r  <= lsum_r + LS_W'({le_r, frac_nxt});
            nz_r    <= nz_r + 1'b1;
            state_r <= last_r ? S_FIN : S_IDLE;
          end
        end

        S_FIN: begin
          cen_r     <= '0;
          rl_r      <= '0;
          rm_r      <= '0;
          rh_r      <= '0;
          fl_r      <= '0;
          hr_r      <= '0;
          harm_en_r <= (fund_lhs >= fund_rhs);
          if (total_r == '0) begin
            state_r <= S_OUT;
          end else if (cfg.sr == '0) begin
            if (nz_r != '0) begin
              op_r       <= OP_LQ;
              md_start_r <= 1'b1;
              state_r    <= S_MD;
            end else begin
              state_r <= S_OUT;
            end
          end else begin
            op_r       <= OP_DEN;
            md_start_r <= 1'b1;
            state_r    <= S_MD;
          end
        end

        S_MD: begin
          if (md_rsp.done) begin
            md_start_r <= 1'b1;
            case (op_r)
              OP_DEN: begin
                den_r <= md_rsp.q[MD_CW-1:0];
                op_r  <= OP_CEN;
              end
              OP_CEN: begin
                cen_r <= md_rsp.q[RES_W-1:0];
                op_r  <= OP_E0;
              end
              OP_E0: begin
                edge_r[0] <= sat_bin(md_rsp.q);
                op_r      <= OP_E1;
              end
              OP_E1: begin
                edge_r[1] <= sat_bin(md_rsp.q);
                op_r      <= OP_E2;
              end
              OP_E2: begin
                edge_r[2] <= sat_bin(md_rsp.q);
                op_r      <= OP_E3;
              end
              OP_E3: begin
                // start the band walk over bins 1..n-1
                edge_r[3]  <= sat_bin(md_rsp.q);
                md_start_r <= 1'b0;
                rd_idx_r   <= CNT_W'(1);
                for (int k = 0; k < 3; k++) bsum_r[k] <= '0;
                state_r    <= S_BAND;
              end
              OP_BL: begin
                rl_r <= sat_ratio(md_rsp.q);
                op_r <= OP_BM;
              end
              OP_BM: begin
                rm_r <= sat_ratio(md_rsp.q);
                op_r <= OP_BH;
              end
              OP_BH: begin
                rh_r <= sat_ratio(md_rsp.q);
                if (harm_en_r) begin
                  md_start_r <= 1'b0;
                  hh_r       <= HH_W'(1);
                  hc_r       <= HC_W'(pkidx_r);
                  hd_r       <= '0;
                  hsum_r     <= '0;
                  state_r    <= S_HARM;
                end else if (nz_r != '0) begin
                  op_r <= OP_LQ;
                end else begin
                  md_start_r <= 1'b0;
                  state_r    <= S_OUT;
                end
              end
              OP_HR: begin
                hr_r <= sat_ratio(md_rsp.q);
                if (nz_r != '0) begin
                  op_r <= OP_LQ;
                end else begin
                  md_start_r <= 1'b0;
                  state_r    <= S_OUT;
                end
              end
              OP_LQ: begin
                lq_r       <= md_rsp.q[31:0];
                md_start_r <= 1'b0;
                acc_r      <= 32'd1 << 30;
                ek_r       <= '0;
                state_r    <= S_EXP;
              end
              default: begin
                fl_r       <= sat_ratio(md_rsp.q);
                md_start_r <= 1'b0;
                state_r    <= S_OUT;
              end
            endcase
          end
        end

        S_BAND: begin
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end else if (!rv_r) begin
            op_r       <= OP_BL;
            md_start_r <= 1'b1;
            state_r    <= S_MD;
          end
        end

        S_HARM: begin
          if (h_active) begin
            if (hd_r == HD_W'(2 * HARM_SPAN)) begin
              hd_r <= '0;
              hh_r <= hh_r + 1'b1;
              hc_r <= hc_r + HC_W'(pkidx_r);
            end else begin
              hd_r <= hd_r + 1'b1;
            end
          end else if (!rv_r) begin
            op_r       <= OP_HR;
            md_start_r <= 1'b1;
            state_r    <= S_MD;
          end
        end

        S_EXP: begin
          acc_r <= acc_nxt;
          ek_r  <= ek_r + 1'b1;
          if (ek_r == 4'd15) begin
            g_r        <= g_full[MD_AW-1:0];
            op_r       <= OP_FL;
            md_start_r <= 1'b1;
            state_r    <= S_MD;
          end
        end

        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r                <= 1'b1;
            out_data_r.centroid_hz     <= cen_r;
            out_data_r.low_ratio       <= rl_r;
            out_data_r.mid_ratio       <= rm_r;
            out_data_r.high_ratio      <= rh_r;
            out_data_r.flatness        <= fl_r;
            out_data_r.harmonic_ratio  <= hr_r;
            out_data_r.peak_index      <= PEAK_W'(pkidx_r);
            total_r <= '0;
            wsum_r  <= '0;
            lsum_r  <= '0;
            nz_r    <= '0;
            pkval_r <= '0;
            pkidx_r <= BIN_AW'(1);
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/spectral_feature_extractor.sv
// ----------------------------------------------------------------------------
// spectral_feature_extractor : centroid, band ratios, flatness, harmonics
// Top level: configuration registers, front end, bin word queue, back end.
// ----------------------------------------------------------------------------
// Bins of one magnitude spectrum arrive one word per accepted cycle, in index
// order, with last_bin set on the final bin; one result word follows each
// spectrum. The front end numbers and classifies every word and parks it in a
// four-word queue, so up to four words are taken even while the back end is
// busy. The back end drains one word per cycle for bin 0, zero bins and bins
// past the store size; a nonzero bin holds it for the 16-step squaring loop
// of the log2 unit. After the last bin the closing pass runs up to 12
// multiply-divide operations on one shared serial unit (each a start, 18
// multiply steps, 66 quotient bits and the hand-back of the quotient), a
// walk over the stored bins 1..n-1 for the band sums, a walk of up to
// HARM_COUNT*(2*HARM_SPAN+1) harmonic window positions and 16 exp2 steps.
// The bin store needs no clearing after reset. The user must write registers
// only while the block is idle; the block itself does not enforce this, and
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module spectral_feature_extractor import sfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // bin words
  input  logic              in_valid,
  input  in_word_t          in_data,
  output logic              in_stall,
  // result words
  output logic              out_valid,
  output out_word_t         out_data,
  input  logic              out_stall,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t cfg_r;

  // bin word queue between front and back end
  q_word_t             q_mem [Q_DEPTH];
  logic [QA_W-1:0]     wp_r;
  logic [QA_W-1:0]     rp_r;
  logic [QA_W:0]       q_cnt_r;
  logic                q_full;
  logic                q_push;
  logic                q_pop;
  q_word_t             q_word;

  assign cfg_ready = 1'b1;

  // hold register values; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sr     <= SR_W'(48000);
      cfg_r.e_low  <= EDGE_W'(20);
      cfg_r.e_lm   <= EDGE_W'(250);
      cfg_r.e_mh   <= EDGE_W'(4000);
      cfg_r.e_high <= EDGE_W'(20000);
      cfg_r.minf   <= MINF_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: cfg_r.sr     <= cfg_data[SR_W-1:0];
        REG_EDGE_LOW:    cfg_r.e_low  <= cfg_data[EDGE_W-1:0];
        REG_EDGE_LM:     cfg_r.e_lm   <= cfg_data[EDGE_W-1:0];
        REG_EDGE_MH:     cfg_r.e_mh   <= cfg_data[EDGE_W-1:0];
        REG_EDGE_HIGH:   cfg_r.e_high <= cfg_data[EDGE_W-1:0];
        REG_MIN_FUND:    cfg_r.minf   <= cfg_data[MINF_W-1:0];
        default: ;
      endcase
    end
  end

  sfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_word)
  );

  assign q_full = (q_cnt_r == (QA_W + 1)'(Q_DEPTH));

  // advance pointers; push and pop may land in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({q_push, q_pop})
        2'b10:   q_cnt_r <= q_cnt_r + 1'b1;
        2'b01:   q_cnt_r <= q_cnt_r - 1'b1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wp_r] <= q_word;
    end
  end

  sfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_mem[rp_r]),
    .q_valid   (q_cnt_r != '0),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // the back end never takes a word from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt_r != '0))
    else $error("bin word taken from empty queue");

  // peak search starts at bin 1, so the peak index is never zero
  a_peak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.peak_index != '0))
    else $error("peak index zero in result word");

  // every ratio field stays within Q1.16 unity
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.low_ratio <= RES_W'(RATIO_ONE)) &&
                  (out_data.mid_ratio <= RES_W'(RATIO_ONE)) &&
                  (out_data.high_ratio <= RES_W'(RATIO_ONE)) &&
                  (out_data.flatness <= RES_W'(RATIO_ONE)) &&
                  (out_data.harmonic_ratio <= RES_W'(RATIO_ONE)))
    else $error("ratio above unity in result word");

endmodule
